/* sv/tnt_pkg.sv */
package tnt_pkg;

    // Internal edge width: coordinates wider than 30 bits are pre-shifted so
    // that every edge and UV delta fits in 31 signed bits.
    localparam int EDGE_W = 31;
    localparam int PROD_W = 62;
    localparam int ACC_W  = 63;
    localparam int MAG_W  = 62;
    localparam int NUM_W  = 80;
    localparam int DEN_W  = 63;
    localparam int QUOT_W = 32;
    localparam int NORM_W = 16;
    localparam int TAN_W  = 32;
    localparam int SQ_W   = 64;

    localparam int NORM_FRAC = 14;
    localparam int TAN_FRAC  = 16;
    localparam int LIMB_W    = 30;

    typedef struct packed {
        logic signed [EDGE_W-1:0] e1x;
        logic signed [EDGE_W-1:0] e1y;
        logic signed [EDGE_W-1:0] e1z;
        logic signed [EDGE_W-1:0] e2x;
        logic signed [EDGE_W-1:0] e2y;
        logic signed [EDGE_W-1:0] e2z;
        logic signed [EDGE_W-1:0] du1;
        logic signed [EDGE_W-1:0] dv1;
        logic signed [EDGE_W-1:0] du2;
        logic signed [EDGE_W-1:0] dv2;
        logic                     uv;
    } t_tri;

endpackage

/* sv/tnt_front.sv */
module tnt_front import tnt_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_tex_u,
    input  logic signed [COORD_WIDTH-1:0] i_tex_v,
    input  logic                          i_uv_present,
    output logic                          o_tri_valid,
    input  logic                          i_tri_ready,
    output t_tri                          o_tri
);

    localparam int W  = COORD_WIDTH;
    localparam int K  = (W > 30) ? W - 30 : 0;
    localparam int DW = W + 2;

    logic [1:0]           r_cnt;
    logic signed [W-1:0]  r_c0 [5];
    logic signed [W-1:0]  r_c1 [5];
    logic signed [W-1:0]  cur  [5];
    logic                 accept;

    // Difference of two coordinates, truncated toward zero by K bits.
    function automatic logic signed [EDGE_W-1:0] delta(input logic signed [W-1:0] x,
                                                       input logic signed [W-1:0] y);
        logic signed [DW-1:0] d;
        logic [DW-1:0]        m;
        d = DW'(x) - DW'(y);
        m = d[DW-1] ? DW'(-d) : DW'(d);
        m = m >> K;
        if (d[DW-1]) begin
            d = -$signed(m);
        end else begin
            d = $signed(m);
        end
        return EDGE_W'(d);
    endfunction

    assign cur[0] = i_pos_x;
    assign cur[1] = i_pos_y;
    assign cur[2] = i_pos_z;
    assign cur[3] = i_tex_u;
    assign cur[4] = i_tex_v;

    assign o_ready     = (r_cnt != 2'd2) || i_tri_ready;
    assign accept      = i_valid && o_ready;
    assign o_tri_valid = i_valid && (r_cnt == 2'd2);

    always_comb begin
        o_tri.e1x = delta(r_c1[0], r_c0[0]);
        o_tri.e1y = delta(r_c1[1], r_c0[1]);
        o_tri.e1z = delta(r_c1[2], r_c0[2]);
        o_tri.e2x = delta(cur[0], r_c0[0]);
        o_tri.e2y = delta(cur[1], r_c0[1]);
        o_tri.e2z = delta(cur[2], r_c0[2]);
        o_tri.du1 = delta(r_c1[3], r_c0[3]);
        o_tri.dv1 = delta(r_c1[4], r_c0[4]);
        o_tri.du2 = delta(cur[3], r_c0[3]);
        o_tri.dv2 = delta(cur[4], r_c0[4]);
        o_tri.uv  = i_uv_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_cnt == 2'd0) begin
            r_c0 <= cur;
        end
        if (accept && r_cnt == 2'd1) begin
            r_c1 <= cur;
        end
    end

endmodule

/* sv/tnt_queue.sv */
module tnt_queue import tnt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_tri i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_tri o_data
);

    t_tri       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* sv/tnt_div.sv */
module tnt_div import tnt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot,
    output logic              o_ovf
);

    localparam int CW = $clog2(NUM_W);

    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic              r_ovf;
    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DEN_W:0]    rem_sh;
    logic              ge;
    logic [DEN_W:0]    rem_n;

    // Restoring division, one numerator bit a cycle. Quotient bits that fall
    // off the top of the register are remembered as an overflow.
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign rem_n  = ge ? rem_sh - {1'b0, r_den} : rem_sh;

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= r_num << 1;
            r_rem  <= rem_n[DEN_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], ge};
            r_ovf  <= r_ovf | r_quot[QUOT_W-1];
        end
    end

endmodule

/* sv/tnt_back.sv */
module tnt_back import tnt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_tri_valid,
    output logic                     o_tri_ready,
    input  t_tri                     i_tri,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [NORM_W-1:0] o_normal_x,
    output logic signed [NORM_W-1:0] o_normal_y,
    output logic signed [NORM_W-1:0] o_normal_z,
    output logic signed [TAN_W-1:0]  o_tan_x,
    output logic signed [TAN_W-1:0]  o_tan_y,
    output logic signed [TAN_W-1:0]  o_tan_z,
    output logic                     o_normal_degenerate,
    output logic                     o_uv_degenerate
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_MAG   = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_NDIV  = 4'd6;
    localparam logic [3:0] S_TDIV  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam logic [QUOT_W-1:0] NORM_ONE = QUOT_W'(1) << NORM_FRAC;
    localparam logic [QUOT_W:0]   TAN_SAT  = (QUOT_W+1)'(1) << (TAN_W - 1);

    logic [3:0]               r_state;
    logic [3:0]               r_step;
    logic [1:0]               r_idx;
    logic                     r_wait;
    t_tri                     r_tri;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_res [7];
    logic [MAG_W-1:0]         r_cm  [3];
    logic [SQ_W-1:0]          r_sum;
    logic [SQ_W-1:0]          r_x;
    logic [SQ_W-1:0]          r_r;
    logic [SQ_W-1:0]          r_bit;
    logic signed [NORM_W-1:0] r_nrm [3];
    logic signed [TAN_W-1:0]  r_tan [3];
    logic                     r_ndeg;
    logic                     r_udeg;

    logic signed [EDGE_W-1:0] mul_a;
    logic signed [EDGE_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [SQ_W-1:0]          sum_n;
    logic [SQ_W-1:0]          sq_t;
    logic [MAG_W-1:0]         an;
    logic [MAG_W-1:0]         ad;
    logic                     div_start;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic                     div_ovf;
    logic [QUOT_W-1:0]        nq;
    logic signed [NORM_W-1:0] nval;
    logic [QUOT_W:0]          tm;
    logic [QUOT_W:0]          tneg;
    logic signed [TAN_W-1:0]  tval;
    logic                     big;

    function automatic logic [MAG_W-1:0] mag(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] m;
        m = v[ACC_W-1] ? -v : v;
        return m[MAG_W-1:0];
    endfunction

    // The shared multiplier walks the cross product, tangent numerators and UV
    // determinant as pairs of products, the second subtracted; S_SQ squares limbs.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_SQ) begin
            mul_a = $signed({1'b0, r_cm[0][LIMB_W-1:0]});
            mul_b = $signed({1'b0, r_cm[0][LIMB_W-1:0]});
        end else begin
            case (r_step)
                4'd0:  begin mul_a = r_tri.e1y; mul_b = r_tri.e2z; end
                4'd1:  begin mul_a = r_tri.e1z; mul_b = r_tri.e2y; end
                4'd2:  begin mul_a = r_tri.e1z; mul_b = r_tri.e2x; end
                4'd3:  begin mul_a = r_tri.e1x; mul_b = r_tri.e2z; end
                4'd4:  begin mul_a = r_tri.e1x; mul_b = r_tri.e2y; end
                4'd5:  begin mul_a = r_tri.e1y; mul_b = r_tri.e2x; end
                4'd6:  begin mul_a = r_tri.dv2; mul_b = r_tri.e1x; end
                4'd7:  begin mul_a = r_tri.dv1; mul_b = r_tri.e2x; end
                4'd8:  begin mul_a = r_tri.dv2; mul_b = r_tri.e1y; end
                4'd9:  begin mul_a = r_tri.dv1; mul_b = r_tri.e2y; end
                4'd10: begin mul_a = r_tri.dv2; mul_b = r_tri.e1z; end
                4'd11: begin mul_a = r_tri.dv1; mul_b = r_tri.e2z; end
                4'd12: begin mul_a = r_tri.du1; mul_b = r_tri.dv2; end
                4'd13: begin mul_a = r_tri.du2; mul_b = r_tri.dv1; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign sum_n = r_sum + SQ_W'($unsigned(r_prod));
    assign sq_t  = r_r + r_bit;
    assign big   = (r_cm[0][MAG_W-1:LIMB_W] != '0) || (r_cm[1][MAG_W-1:LIMB_W] != '0)
                || (r_cm[2][MAG_W-1:LIMB_W] != '0);

    assign an = mag(r_res[3]);
    assign ad = mag(r_res[6]);

    // Both divisions are round(a * 2^F / d), half away from zero, formed as
    // floor((a * 2^(F+1) + d) / (2 * d)).
    always_comb begin
        div_start = (r_state == S_NDIV || r_state == S_TDIV) && !r_wait;
        if (r_state == S_NDIV) begin
            div_num = NUM_W'({r_cm[0], {(NORM_FRAC+1){1'b0}}}) + NUM_W'(r_r);
            div_den = DEN_W'({r_r, 1'b0});
        end else begin
            div_num = NUM_W'({an, {(TAN_FRAC+1){1'b0}}}) + NUM_W'(ad);
            div_den = DEN_W'({ad, 1'b0});
        end
    end

    always_comb begin
        nq   = (div_ovf || div_quot > NORM_ONE) ? NORM_ONE : div_quot;
        nval = r_res[0][ACC_W-1] ? -$signed(nq[NORM_W-1:0]) : $signed(nq[NORM_W-1:0]);
        tm   = (div_ovf || {1'b0, div_quot} > TAN_SAT) ? TAN_SAT : {1'b0, div_quot};
        tneg = -tm;
        if (r_res[3][ACC_W-1] != r_res[6][ACC_W-1]) begin
            tval = $signed(tneg[TAN_W-1:0]);
        end else if (tm == TAN_SAT) begin
            tval = $signed(TAN_SAT[TAN_W-1:0] - TAN_W'(1));
        end else begin
            tval = $signed(tm[TAN_W-1:0]);
        end
    end

    tnt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    assign o_tri_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_wait  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_tri_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step == 4'd14) begin
                        r_state <= S_MAG;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_MAG: begin
                    r_step <= '0;
                    r_idx  <= '0;
                    r_wait <= 1'b0;
                    if (r_res[0] == '0 && r_res[1] == '0 && r_res[2] == '0) begin
                        r_state <= S_TDIV;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (!big) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd3) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_bit[0]) begin
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV, S_TDIV: begin
                    if (r_state == S_TDIV && !(r_tri.uv && r_res[6] != '0)) begin
                        r_state <= S_OUT;
                    end else if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_done) begin
                        r_wait <= 1'b0;
                        r_idx  <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                        if (r_idx == 2'd2) begin
                            r_state <= (r_state == S_NDIV) ? S_TDIV : S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_tri_valid) begin
                    r_tri <= i_tri;
                end
            end
            S_MUL: begin
                if (r_step != 4'd14) begin
                    r_prod <= mul_p;
                end
                if (r_step != 4'd0) begin
                    if (r_step[0]) begin
                        r_acc <= ACC_W'(r_prod);
                    end else begin
                        for (int i = 0; i < 6; i++) begin
                            r_res[i] <= r_res[i+1];
                        end
                        r_res[6] <= r_acc - ACC_W'(r_prod);
                    end
                end
            end
            S_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_cm[i]  <= mag(r_res[i]);
                    r_nrm[i] <= '0;
                    r_tan[i] <= '0;
                end
                r_ndeg <= (r_res[0] == '0 && r_res[1] == '0 && r_res[2] == '0);
                r_udeg <= r_tri.uv && (r_res[6] == '0);
                r_sum  <= '0;
            end
            S_SHIFT: begin
                if (big) begin
                    for (int i = 0; i < 3; i++) begin
                        r_cm[i] <= r_cm[i] >> 1;
                    end
                end
            end
            S_SQ: begin
                if (r_step != 4'd3) begin
                    r_prod  <= mul_p;
                    r_cm[0] <= r_cm[1];
                    r_cm[1] <= r_cm[2];
                    r_cm[2] <= r_cm[0];
                end
                if (r_step != 4'd0) begin
                    r_sum <= sum_n;
                end
                r_x   <= sum_n;
                r_r   <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
            end
            S_SQRT: begin
                if (r_x >= sq_t) begin
                    r_x <= r_x - sq_t;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_NDIV: begin
                if (r_wait && div_done) begin
                    r_nrm[0] <= r_nrm[1];
                    r_nrm[1] <= r_nrm[2];
                    r_nrm[2] <= nval;
                    r_cm[0]  <= r_cm[1];
                    r_cm[1]  <= r_cm[2];
                    r_cm[2]  <= r_cm[0];
                    r_res[0] <= r_res[1];
                    r_res[1] <= r_res[2];
                    r_res[2] <= r_res[0];
                end
            end
            S_TDIV: begin
                if (r_wait && div_done) begin
                    r_tan[0] <= r_tan[1];
                    r_tan[1] <= r_tan[2];
                    r_tan[2] <= tval;
                    r_res[3] <= r_res[4];
                    r_res[4] <= r_res[5];
                    r_res[5] <= r_res[3];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_normal_x          = r_nrm[0];
    assign o_normal_y          = r_nrm[1];
    assign o_normal_z          = r_nrm[2];
    assign o_tan_x             = r_tan[0];
    assign o_tan_y             = r_tan[1];
    assign o_tan_z             = r_tan[2];
    assign o_normal_degenerate = r_ndeg;
    assign o_uv_degenerate     = r_udeg;

endmodule

/* sv/triangle_normal_and_tangent_top.sv */
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_pos_x/y/z, i_tex_u/v
// out       output     o_out_valid / i_out_ready    o_normal_*, o_tan_*, flags
// cfg       input      i_cfg_we                     i_cfg_wdata (uv_present)
//
// The first two vertices of a triangle are accepted as they arrive. The third
// is queued; the back end forms the products, scales and squares the normal,
// takes its square root and runs up to six divisions through the one
// bit-serial divider. A zero cross product skips scaling, square root and
// normal divisions; the tangent divisions run only with UVs and a nonzero UV
// determinant. Reset is synchronous, active low. The two-entry queue lets
// vertices keep arriving while the back end works or waits on the output.
module triangle_normal_and_tangent_top import tnt_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_tex_u,
    input  logic signed [COORD_WIDTH-1:0] i_tex_v,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [NORM_W-1:0]      o_normal_x,
    output logic signed [NORM_W-1:0]      o_normal_y,
    output logic signed [NORM_W-1:0]      o_normal_z,
    output logic signed [TAN_W-1:0]       o_tan_x,
    output logic signed [TAN_W-1:0]       o_tan_y,
    output logic signed [TAN_W-1:0]       o_tan_z,
    output logic                          o_normal_degenerate,
    output logic                          o_uv_degenerate,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata
);

    logic r_uv;
    logic f_valid;
    logic f_ready;
    t_tri f_tri;
    logic q_valid;
    logic q_ready;
    t_tri q_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv <= 1'b0;
        end else if (i_cfg_we) begin
            r_uv <= i_cfg_wdata;
        end
    end

    tnt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_tex_u      (i_tex_u),
        .i_tex_v      (i_tex_v),
        .i_uv_present (r_uv),
        .o_tri_valid  (f_valid),
        .i_tri_ready  (f_ready),
        .o_tri        (f_tri)
    );

    tnt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_tri),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_tri)
    );

    tnt_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_tri_valid         (q_valid),
        .o_tri_ready         (q_ready),
        .i_tri               (q_tri),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_normal_x          (o_normal_x),
        .o_normal_y          (o_normal_y),
        .o_normal_z          (o_normal_z),
        .o_tan_x             (o_tan_x),
        .o_tan_y             (o_tan_y),
        .o_tan_z             (o_tan_z),
        .o_normal_degenerate (o_normal_degenerate),
        .o_uv_degenerate     (o_uv_degenerate)
    );

endmodule
